[hdl/cse_pkg.sv]
// Shared types and constants for the 6502 subset execute block.
package cse_pkg;

  // Input transaction: opcode, operands and zero-page read data
  typedef struct packed {
    logic [7:0] func;
    logic [7:0] operand_lo;
    logic [7:0] operand_hi;
    logic [7:0] read_data;
  } in_t;

  // Result transaction: memory write, next pc, cycles, flags, illegal
  typedef struct packed {
    logic       write_enable;
    logic [8:0] write_addr;
    logic [7:0] write_data;
    logic [15:0] next_pc;
    logic [2:0] cycle_count;
    logic [2:0] flags;
    logic       illegal;
  } out_t;

  // Program counter after reset, start of ROM
  localparam logic [15:0] PC_RESET = 16'hF000;
  localparam logic [7:0]  SIGN_BIT = 8'h80;
  localparam logic [7:0]  HIGH_BYTE_ONES = 8'hFF;

  // Supported opcodes
  localparam logic [7:0] OP_STY_ZP  = 8'h84;
  localparam logic [7:0] OP_STA_ZP  = 8'h85;
  localparam logic [7:0] OP_STX_ZP  = 8'h86;
  localparam logic [7:0] OP_STA_ZPX = 8'h95;
  localparam logic [7:0] OP_DEY     = 8'h88;
  localparam logic [7:0] OP_INY     = 8'hC8;
  localparam logic [7:0] OP_INX     = 8'hE8;
  localparam logic [7:0] OP_LDY_IMM = 8'hA0;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
  localparam logic [7:0] OP_CPY_IMM = 8'hC0;
  localparam logic [7:0] OP_CPX_IMM = 8'hE0;
  localparam logic [7:0] OP_BNE     = 8'hD0;
  localparam logic [7:0] OP_INC_ZP  = 8'hE6;
  localparam logic [7:0] OP_NOP     = 8'hEA;
  localparam logic [7:0] OP_JMP_ABS = 8'h4C;

endpackage

[hdl/cse_exec.sv]
// Architectural state and single-pass instruction execute for the 6502 subset.
module cse_exec (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  cse_pkg::in_t  item,
  input  logic          cfg_write_enable,
  input  logic [15:0]   cfg_write_data,
  output cse_pkg::out_t result
);

  logic [15:0] pc, pc_next;
  logic [7:0]  acc, acc_next;
  logic [7:0]  index_x, index_x_next;
  logic [7:0]  index_y, index_y_next;
  logic        zero_flag, zero_flag_next;
  logic        carry_flag, carry_flag_next;
  logic        sign_flag, sign_flag_next;
  logic        halted, halted_next;

  logic [15:0] pc1, pc2, branch_target;
  logic [7:0]  lo, inc_val, y_dec, y_inc, x_inc, cpx_diff;
  logic        we, bad;
  logic [8:0]  waddr;
  logic [7:0]  wdata;
  logic [2:0]  cyc;

  // Shared adders
  assign lo            = item.operand_lo;
  assign pc1           = pc + 16'd1;
  assign pc2           = pc + 16'd2;
  assign branch_target = pc2 + {(lo[7] ? cse_pkg::HIGH_BYTE_ONES : 8'h00), lo};
  assign inc_val       = item.read_data + 8'd1;
  assign y_dec         = index_y - 8'd1;
  assign y_inc         = index_y + 8'd1;
  assign x_inc         = index_x + 8'd1;
  assign cpx_diff      = index_x - lo;

  // Decode and execute one instruction
  always_comb begin
    pc_next         = pc;
    acc_next        = acc;
    index_x_next    = index_x;
    index_y_next    = index_y;
    zero_flag_next  = zero_flag;
    carry_flag_next = carry_flag;
    sign_flag_next  = sign_flag;
    halted_next     = halted;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    cyc   = 3'd0;
    bad   = 1'b0;
    if (halted) begin
      bad = 1'b1;
    end else begin
      unique case (item.func)
        cse_pkg::OP_STY_ZP: begin
          we = 1'b1; waddr = {1'b0, lo}; wdata = index_y; pc_next = pc2; cyc = 3'd3;
        end
        cse_pkg::OP_STA_ZP: begin
          we = 1'b1; waddr = {1'b0, lo}; wdata = acc; pc_next = pc2; cyc = 3'd3;
        end
        cse_pkg::OP_STX_ZP: begin
          we = 1'b1; waddr = {1'b0, lo}; wdata = index_x; pc_next = pc2; cyc = 3'd3;
        end
        cse_pkg::OP_STA_ZPX: begin
          we = 1'b1; waddr = {1'b0, lo} + {1'b0, index_x}; wdata = acc;
          pc_next = pc2; cyc = 3'd4;
        end
        cse_pkg::OP_DEY: begin
          index_y_next = y_dec; zero_flag_next = (y_dec == 8'h00);
          pc_next = pc1; cyc = 3'd2;
        end
        cse_pkg::OP_INY: begin
          index_y_next = y_inc; zero_flag_next = (y_inc == 8'h00);
          pc_next = pc1; cyc = 3'd2;
        end
        cse_pkg::OP_INX: begin
          index_x_next = x_inc; zero_flag_next = (x_inc == 8'h00);
          pc_next = pc1; cyc = 3'd2;
        end
        cse_pkg::OP_LDY_IMM: begin
          index_y_next = lo; zero_flag_next = (lo == 8'h00); pc_next = pc2; cyc = 3'd2;
        end
        cse_pkg::OP_LDX_IMM: begin
          index_x_next = lo; zero_flag_next = (lo == 8'h00); pc_next = pc2; cyc = 3'd2;
        end
        cse_pkg::OP_LDA_IMM: begin
          acc_next = lo; zero_flag_next = (lo == 8'h00); pc_next = pc2; cyc = 3'd2;
        end
        cse_pkg::OP_LDA_ZP: begin
          acc_next = item.read_data; zero_flag_next = (item.read_data == 8'h00);
          pc_next = pc2; cyc = 3'd3;
        end
        cse_pkg::OP_CPY_IMM: begin
          zero_flag_next = (lo == index_y); pc_next = pc2; cyc = 3'd2;
        end
        cse_pkg::OP_CPX_IMM: begin
          carry_flag_next = (index_x >= lo);
          zero_flag_next  = (index_x == lo);
          sign_flag_next  = ((cpx_diff & cse_pkg::SIGN_BIT) != 8'h00);
          pc_next = pc2; cyc = 3'd2;
        end
        cse_pkg::OP_BNE: begin
          if (zero_flag) begin
            pc_next = pc2; cyc = 3'd2;
          end else begin
            pc_next = branch_target; cyc = 3'd3;
          end
        end
        cse_pkg::OP_INC_ZP: begin
          we = 1'b1; waddr = {1'b0, lo}; wdata = inc_val;
          zero_flag_next = (inc_val == 8'h00); pc_next = pc2; cyc = 3'd5;
        end
        cse_pkg::OP_NOP: begin
          pc_next = pc1; cyc = 3'd2;
        end
        cse_pkg::OP_JMP_ABS: begin
          pc_next = {item.operand_hi, lo}; cyc = 3'd3;
        end
        default: begin
          bad = 1'b1; halted_next = 1'b1;
        end
      endcase
    end
    // Drop any effect of an unsupported opcode except the halt
    if (bad) begin
      pc_next = pc;
      we    = 1'b0;
      waddr = '0;
      wdata = '0;
      cyc   = 3'd0;
    end
  end

  // Form the result transaction
  always_comb begin
    result.write_enable = we;
    result.write_addr   = waddr;
    result.write_data   = wdata;
    result.next_pc      = pc_next;
    result.cycle_count  = cyc;
    result.flags        = {sign_flag_next, carry_flag_next, zero_flag_next};
    result.illegal      = bad;
  end

  // Commit state when an instruction executes; a config write loads the pc and takes priority
  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= cse_pkg::PC_RESET;
      acc        <= '0;
      index_x    <= '0;
      index_y    <= '0;
      zero_flag  <= 1'b0;
      carry_flag <= 1'b0;
      sign_flag  <= 1'b0;
      halted     <= 1'b0;
    end else if (cfg_write_enable) begin
      pc <= cfg_write_data;
    end else if (fire) begin
      pc         <= pc_next;
      acc        <= acc_next;
      index_x    <= index_x_next;
      index_y    <= index_y_next;
      zero_flag  <= zero_flag_next;
      carry_flag <= carry_flag_next;
      sign_flag  <= sign_flag_next;
      halted     <= halted_next;
    end
  end

endmodule

[hdl/cpu6502_subset_execute_top.sv]
// Top level of the 6502 subset execute block: input and result registers around execute.
//
//   channel  direction  handshake                       payload
//   in       input      in_valid / in_ready             in_data (cse_pkg::in_t)
//   out      output     out_valid / out_ready           out_data (cse_pkg::out_t)
//   cfg      input      cfg_write_enable (no wait)      cfg_write_data (start address)
//
// One instruction per cycle sustained while out_ready stays high; an accepted instruction is held in the
// input register, and the combinational execute stage feeds its result into the result register.
// Reset loads the pc with 0xF000 and clears A, X, Y, the flags and the halt.
// A stalled result holds the execute stage, which in turn holds the input register;
// in_ready stays high as long as the input register can advance.
module cpu6502_subset_execute_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cse_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cse_pkg::out_t out_data,
  input  logic          cfg_write_enable,
  input  logic [15:0]   cfg_write_data
);

  logic          in_full;
  cse_pkg::in_t  in_hold;
  logic          out_full;
  cse_pkg::out_t out_hold;
  cse_pkg::out_t exec_result;
  logic          exec_fire;

  // Advance the execute stage when the result register is free or draining
  assign exec_fire = in_full && (!out_full || out_ready);
  assign in_ready  = !in_full || exec_fire;

  // Hold the accepted transaction until it executes
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_hold <= in_data;
    end
  end

  cse_exec u_exec (
    .clk              (clk),
    .rst              (rst),
    .fire             (exec_fire),
    .item             (in_hold),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .result           (exec_result)
  );

  // Capture the result; hold it until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (exec_fire) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_hold <= exec_result;
    end
  end

  assign out_valid = out_full;
  assign out_data  = out_hold;

  // An empty result register never blocks the input
  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !out_full |-> in_ready)
    else $error("input stalled with empty result register");

  // Illegal results carry no cycles and no write
  a_illegal_quiet : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.illegal |->
      out_data.cycle_count == 3'd0 && !out_data.write_enable)
    else $error("illegal result with side effects");

  // No write means zero address and data
  a_no_write_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.write_enable |->
      out_data.write_addr == 9'd0 && out_data.write_data == 8'd0)
    else $error("write fields nonzero without write enable");

  // A queued item executes in the same cycle as the result register is taken, so it stays full
  a_drain_advances : assert property (@(posedge clk) disable iff (rst)
    in_full && out_full && out_ready |=> out_full)
    else $error("result register failed to refill");

endmodule
